### rtl/core/fmpc_pkg.sv
// Shared types, codes and reset values of the four-motor position controller.
package fmpc_pkg;

	// Channel count and field widths
	localparam int NUM_CH     = 4;
	localparam int CH_W       = 2;
	localparam int POS_W      = 16;
	localparam int DRV_W      = 10;
	localparam int GAIN_W     = 8;
	localparam int TCH_W      = 3;
	localparam int REQ_W      = 2;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 10;
	localparam int IN_DATA_W  = 24;
	localparam int OUT_DATA_W = 48;

	// Kick starts once the error magnitude reaches this many counts
	localparam logic [POS_W-1:0] KICK_THR = 16'd10;
	// Product boundary between proportional and full drive
	localparam logic [14:0] PROD_LIMIT = 15'd1000;
	localparam logic [14:0] PROD_SAT   = 15'h7FFF;

	// Request codes on s_tuser
	localparam logic [REQ_W-1:0] REQ_TICK  = 2'd0;
	localparam logic [REQ_W-1:0] REQ_PULSE = 2'd1;
	localparam logic [REQ_W-1:0] REQ_SET   = 2'd2;

	// Command kinds held in the queue
	localparam logic [1:0] CMD_TICK  = 2'd0;
	localparam logic [1:0] CMD_PULSE = 2'd1;
	localparam logic [1:0] CMD_SET   = 2'd2;
	localparam logic [1:0] CMD_NOP   = 2'd3;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_GAIN      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CTRL_EN   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_TEN_EN    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_TEN_CH    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_DRV_MAX   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_DRV_INIT  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_DRV_MIN   = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_STOP_BAND = 3'd7;

	typedef struct packed {
		logic [GAIN_W-1:0] gain;
		logic              ctrl_en;
		logic              ten_en;
		logic [TCH_W-1:0]  ten_ch;
		logic [DRV_W-1:0]  drv_max;
		logic [DRV_W-1:0]  drv_init;
		logic [DRV_W-1:0]  drv_min;
		logic [DRV_W-1:0]  stop_band;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		gain:      8'd25,
		ctrl_en:   1'b0,
		ten_en:    1'b0,
		ten_ch:    3'd1,
		drv_max:   10'd500,
		drv_init:  10'd400,
		drv_min:   10'd90,
		stop_band: 10'd50
	};

	typedef struct packed {
		logic [1:0]       kind;
		logic [CH_W-1:0]  ch;
		logic [POS_W-1:0] target;
	} cmd_t;

endpackage

### rtl/core/fmpc_front.sv
// Front end: decodes input transactions into commands and queues them.
module fmpc_front (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// [1:0] channel, [17:2] target_value, [23:18] zero
	input  logic [fmpc_pkg::IN_DATA_W-1:0]    s_tdata,
	// [1:0] req_type
	input  logic [fmpc_pkg::REQ_W-1:0]        s_tuser,
	input  logic                              pop,
	output logic                              cmd_valid,
	output fmpc_pkg::cmd_t                    cmd
);
	import fmpc_pkg::*;

	cmd_t       mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	cmd_t       dec;
	logic       push;
	logic       do_pop;

	// Classify the request
	always_comb begin
		dec.ch     = s_tdata[CH_W-1:0];
		dec.target = s_tdata[CH_W+POS_W-1:CH_W];
		unique case (s_tuser)
			REQ_TICK:  dec.kind = CMD_TICK;
			REQ_PULSE: dec.kind = CMD_PULSE;
			REQ_SET:   dec.kind = CMD_SET;
			default:   dec.kind = CMD_NOP;
		endcase
		// Drop pulses and targets aimed past the last channel
		if (int'(s_tdata[CH_W-1:0]) >= NUM_CH && dec.kind != CMD_TICK)
			dec.kind = CMD_NOP;
	end

	assign s_tready  = (count_q != 2'd2);
	assign push      = s_tvalid && s_tready;
	assign cmd_valid = (count_q != 2'd0);
	assign do_pop    = pop && cmd_valid;
	assign cmd       = mem_q[rd_ptr_q];

	// Store commands
	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= dec;
	end

	// Advance queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push)
				wr_ptr_q <= ~wr_ptr_q;
			if (do_pop)
				rd_ptr_q <= ~rd_ptr_q;
			unique case ({push, do_pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

### rtl/core/fmpc_back.sv
// Back end: channel state, per-channel update lanes and the output register.
module fmpc_back (
	input  logic                              clk,
	input  logic                              arst_n,
	input  fmpc_pkg::cfg_t                    cfg,
	input  logic                              cmd_valid,
	input  fmpc_pkg::cmd_t                    cmd,
	output logic                              pop,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [fmpc_pkg::OUT_DATA_W-1:0]   m_tdata
);
	import fmpc_pkg::*;

	typedef struct packed {
		logic             kick;
		logic             moving;
		logic             fwd;
		logic [DRV_W-1:0] drive;
	} lane_t;

	logic [POS_W-1:0]      tgt_q  [NUM_CH];
	logic [POS_W-1:0]      cnt_q  [NUM_CH];
	lane_t                 lane_q [NUM_CH];
	logic [POS_W-1:0]      tgt_d  [NUM_CH];
	logic [POS_W-1:0]      cnt_d  [NUM_CH];
	lane_t                 lane_d [NUM_CH];
	lane_t                 tick_d [NUM_CH];
	logic [OUT_DATA_W-1:0] pack_d;
	logic                  m_tvalid_q;
	logic [OUT_DATA_W-1:0] m_tdata_q;

	// Drive decision once no kick is pending
	function automatic lane_t drive_step(lane_t l, logic [POS_W-1:0] mag,
			logic [14:0] prod, cfg_t c);
		lane_t r;
		r = l;
		if (mag < {{(POS_W-DRV_W){1'b0}}, c.stop_band}) begin
			r.drive  = '0;
			r.moving = 1'b0;
		end else if (prod > PROD_LIMIT) begin
			r.drive = c.drv_max;
		end else if (prod < PROD_LIMIT) begin
			r.drive = (prod[DRV_W-1:0] > c.drv_min) ? prod[DRV_W-1:0] : c.drv_min;
		end
		return r;
	endfunction

	// One tick on one lane; twice covers the tension channel in control mode
	function automatic lane_t lane_tick(lane_t l, logic [POS_W-1:0] tgt,
			logic [POS_W-1:0] cnt, logic upd, logic twice, cfg_t c);
		lane_t            r;
		logic [POS_W:0]   err;
		logic [POS_W:0]   neg;
		logic [POS_W-1:0] mag;
		logic [23:0]      prod_full;
		logic [14:0]      prod;
		r         = l;
		err       = {tgt[POS_W-1], tgt} - {cnt[POS_W-1], cnt};
		neg       = -err;
		mag       = err[POS_W] ? neg[POS_W-1:0] : err[POS_W-1:0];
		prod_full = c.gain * mag;
		prod      = (prod_full > {9'd0, PROD_SAT}) ? PROD_SAT : prod_full[14:0];
		if (upd) begin
			r.fwd = !err[POS_W] && (err != '0);
			if (l.kick) begin
				if (mag >= KICK_THR) begin
					r.kick  = 1'b0;
					r.drive = c.drv_init;
					if (twice)
						r = drive_step(r, mag, prod, c);
				end
			end else begin
				r = drive_step(r, mag, prod, c);
			end
		end
		return r;
	endfunction

	// Compute tick results in every lane
	always_comb begin
		for (int i = 0; i < NUM_CH; i++) begin
			logic hit;
			hit = cfg.ten_en && (cfg.ten_ch == TCH_W'(i + 1));
			tick_d[i] = lane_tick(lane_q[i], tgt_q[i], cnt_q[i], cfg.ctrl_en || hit,
				cfg.ctrl_en && hit, cfg);
		end
	end

	// Select next channel state by command kind
	always_comb begin
		for (int i = 0; i < NUM_CH; i++) begin
			tgt_d[i]  = tgt_q[i];
			cnt_d[i]  = cnt_q[i];
			lane_d[i] = lane_q[i];
		end
		unique case (cmd.kind)
			CMD_TICK: begin
				for (int i = 0; i < NUM_CH; i++)
					lane_d[i] = tick_d[i];
			end
			CMD_PULSE: begin
				cnt_d[cmd.ch] = lane_q[cmd.ch].fwd ? cnt_q[cmd.ch] + 16'd1
				                                   : cnt_q[cmd.ch] - 16'd1;
			end
			CMD_SET: begin
				tgt_d[cmd.ch]         = cmd.target;
				lane_d[cmd.ch].kick   = 1'b1;
				lane_d[cmd.ch].moving = 1'b1;
			end
			default: ;
		endcase
	end

	// Pack the result: drives from channel zero up, then direction and active bits
	always_comb begin
		pack_d = '0;
		for (int i = 0; i < NUM_CH; i++) begin
			pack_d[i*DRV_W +: DRV_W]          = lane_d[i].drive;
			pack_d[NUM_CH*DRV_W + i]          = lane_d[i].fwd;
			pack_d[NUM_CH*DRV_W + NUM_CH + i] = lane_d[i].moving;
		end
	end

	assign pop      = cmd_valid && (!m_tvalid_q || m_tready);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// Commit channel state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_CH; i++) begin
				tgt_q[i]  <= '0;
				cnt_q[i]  <= '0;
				lane_q[i] <= '0;
			end
			m_tvalid_q <= 1'b0;
		end else begin
			if (pop) begin
				for (int i = 0; i < NUM_CH; i++) begin
					tgt_q[i]  <= tgt_d[i];
					cnt_q[i]  <= cnt_d[i];
					lane_q[i] <= lane_d[i];
				end
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// Hold the result until taken
	always_ff @(posedge clk) begin
		if (pop)
			m_tdata_q <= pack_d;
	end

endmodule

### rtl/core/four_motor_proportional_position_control.sv
// Top level of the four-motor proportional position controller.
// Path: an accepted item is written into the command queue, then into the output register.
// Throughput: one item per cycle while m_tready holds; a two-entry command queue decouples the sides.
// The per-channel update lanes run in parallel, one multiplier per lane.
// Reset (arst_n low) clears all channel state, empties the queue and the
// output register, and returns the configuration registers to their defaults.
module four_motor_proportional_position_control (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// [1:0] channel, [17:2] target_value, [23:18] zero
	input  logic [fmpc_pkg::IN_DATA_W-1:0]    s_tdata,
	// [1:0] req_type
	input  logic [fmpc_pkg::REQ_W-1:0]        s_tuser,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// [9:0] drive_ch0, [19:10] drive_ch1, [29:20] drive_ch2, [39:30] drive_ch3,
	// [43:40] forward_bits, [47:44] active_bits
	output logic [fmpc_pkg::OUT_DATA_W-1:0]   m_tdata,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [fmpc_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [fmpc_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import fmpc_pkg::*;

	cfg_t cfg_q;
	logic q_valid;
	logic q_pop;
	cmd_t q_cmd;

	assign cfg_ready = 1'b1;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_GAIN:      cfg_q.gain      <= cfg_data[GAIN_W-1:0];
				CFG_CTRL_EN:   cfg_q.ctrl_en   <= cfg_data[0];
				CFG_TEN_EN:    cfg_q.ten_en    <= cfg_data[0];
				CFG_TEN_CH:    cfg_q.ten_ch    <= cfg_data[TCH_W-1:0];
				CFG_DRV_MAX:   cfg_q.drv_max   <= cfg_data[DRV_W-1:0];
				CFG_DRV_INIT:  cfg_q.drv_init  <= cfg_data[DRV_W-1:0];
				CFG_DRV_MIN:   cfg_q.drv_min   <= cfg_data[DRV_W-1:0];
				CFG_STOP_BAND: cfg_q.stop_band <= cfg_data[DRV_W-1:0];
				default: ;
			endcase
		end
	end

	fmpc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.pop       (q_pop),
		.cmd_valid (q_valid),
		.cmd       (q_cmd)
	);

	fmpc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.cmd_valid (q_valid),
		.cmd       (q_cmd),
		.pop       (q_pop),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

endmodule

### rtl/core/fmpc_chk.sv
// Port-level checker for the position controller, bound to the top level.
module fmpc_chk (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              s_tvalid,
	input logic                              s_tready,
	input logic                              m_tvalid,
	input logic                              m_tready,
	input logic [fmpc_pkg::OUT_DATA_W-1:0]   m_tdata
);
	import fmpc_pkg::*;

	logic [2:0] pend_q;
	logic       in_acc;
	logic       out_acc;

	assign in_acc  = s_tvalid && s_tready;
	assign out_acc = m_tvalid && m_tready;

	// Track transactions accepted but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			pend_q <= 3'd0;
		else
			pend_q <= pend_q + {2'd0, in_acc} - {2'd0, out_acc};
	end

	// Hold a stalled result
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// No result without an outstanding transaction
	a_no_invent: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> pend_q != 3'd0)
		else $error("result without input transaction");

	// Back pressure only once the queue holds two items
	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> pend_q >= 3'd2)
		else $error("input stalled with room in the queue");

	// Queue plus output register bound the items in flight
	a_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q <= 3'd3)
		else $error("too many items in flight");

endmodule

bind four_motor_proportional_position_control fmpc_chk u_fmpc_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
